// ===== hdl/text_console_writer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text console writer.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 4;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int CELL_W    = COLOR_W + CHAR_W;
  localparam int TAB_CNT_W = $clog2(TAB_WIDTH + 1);

  localparam logic [CHAR_W-1:0]  CH_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0]  CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0]  CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'h08;

  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h0F;
  localparam logic [CELL_W-1:0]  RESET_BLANK  = {COLOR_RESET, CH_BLANK};

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_SET   = 2'd2,
    MODE_CLEAR = 2'd3
  } tcw_mode_e;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } tcw_pos_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } tcw_ram_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
  } tcw_result_t;

endpackage

// ===== hdl/tcw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Screen cell memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_ram (
  input  logic                          clk_i,
  input  tcw_pkg::tcw_ram_req_t         req_i,
  output logic [tcw_pkg::CELL_W-1:0]    rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] cells_q [CELLS];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      cells_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= cells_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tcw_addr_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Shared address unit: turns a screen position into a linear cell address.
// ----------------------------------------------------------------------------
module tcw_addr_unit (
  input  tcw_pkg::tcw_pos_t             pos_i,
  output logic [tcw_pkg::ADDR_W-1:0]    addr_o
);
  import tcw_pkg::*;

  // Row times the line length plus the column.
  assign addr_o = ADDR_W'(pos_i.row) * ADDR_W'(COLUMNS) + ADDR_W'(pos_i.col);

endmodule

// ===== hdl/tcw_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_seq
// Sequencer of the console: cursor, character handling and memory sweeps.
// ----------------------------------------------------------------------------
module tcw_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::COL_W-1:0]     col_i,
  input  logic [tcw_pkg::ROW_W-1:0]     row_i,
  input  logic [tcw_pkg::COLOR_W-1:0]   color_i,
  output tcw_pkg::tcw_pos_t             pos_o,
  input  logic [tcw_pkg::ADDR_W-1:0]    addr_i,
  output tcw_pkg::tcw_ram_req_t         ram_req_o,
  input  logic [tcw_pkg::CELL_W-1:0]    ram_rdata_i,
  output logic                          done_o,
  output tcw_pkg::tcw_result_t          result_o
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_BACK,
    S_READ,
    S_READ_WAIT,
    S_SCROLL,
    S_SCROLL_END,
    S_CLEAR
  } state_e;

  state_e                state_q, state_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [CHAR_W-1:0]     ch_q, ch_d;
  tcw_pos_t              rpos_q, rpos_d;
  logic [TAB_CNT_W-1:0]  tab_left_q, tab_left_d;
  logic [ADDR_W-1:0]     idx_q, idx_d;
  logic                  pend_q, pend_d;
  logic [ADDR_W-1:0]     pend_addr_q, pend_addr_d;
  logic                  pend_blank_q, pend_blank_d;
  logic                  scrolled_q, scrolled_d;
  logic                  done_q, done_d;
  tcw_result_t           res_q, res_d;

  logic                  fin;
  logic [CELL_W-1:0]     fin_cell;
  logic                  start_scroll;
  logic                  accept;
  logic [CELL_W-1:0]     blank_cell;

  assign accept     = start && (state_q == S_IDLE);
  assign blank_cell = {color_i, CH_BLANK};

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    ch_d         = ch_q;
    rpos_d       = rpos_q;
    tab_left_d   = tab_left_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    pend_blank_d = pend_blank_q;
    scrolled_d   = scrolled_q;
    done_d       = 1'b0;
    res_d        = res_q;
    fin          = 1'b0;
    fin_cell     = '0;
    start_scroll = 1'b0;
    pos_o.col    = col_q;
    pos_o.row    = row_q;
    ram_req_o    = '0;

    case (state_q)
      S_INIT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q;
        ram_req_o.wdata = RESET_BLANK;
        idx_d           = idx_q + 1'b1;
        if (idx_q == ADDR_W'(CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          scrolled_d = 1'b0;
          case (tcw_mode_e'(mode_i))
            MODE_PUT: begin
              case (char_code_i)
                CH_NEWLINE: begin
                  col_d = '0;
                  if (row_q == ROW_W'(ROWS - 1)) begin
                    tab_left_d   = '0;
                    start_scroll = 1'b1;
                  end else begin
                    row_d = row_q + 1'b1;
                    fin   = 1'b1;
                  end
                end
                CH_RETURN: begin
                  col_d = '0;
                  fin   = 1'b1;
                end
                CH_TAB: begin
                  ch_d       = CH_BLANK;
                  tab_left_d = TAB_CNT_W'(TAB_WIDTH) - TAB_CNT_W'(col_q % TAB_WIDTH);
                  state_d    = S_PUT;
                end
                CH_BACKSPACE: begin
                  if (col_q == '0 && row_q == '0) begin
                    fin = 1'b1;
                  end else begin
                    if (col_q == '0) begin
                      row_d = row_q - 1'b1;
                      col_d = COL_W'(COLUMNS - 1);
                    end else begin
                      col_d = col_q - 1'b1;
                    end
                    state_d = S_BACK;
                  end
                end
                default: begin
                  ch_d       = char_code_i;
                  tab_left_d = TAB_CNT_W'(1);
                  state_d    = S_PUT;
                end
              endcase
            end
            MODE_READ: begin
              rpos_d.col = (col_i > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : col_i;
              rpos_d.row = (row_i > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : row_i;
              state_d    = S_READ;
            end
            MODE_SET: begin
              col_d = (col_i > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : col_i;
              row_d = (row_i > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : row_i;
              fin   = 1'b1;
            end
            default: begin
              col_d   = '0;
              row_d   = '0;
              idx_d   = '0;
              state_d = S_CLEAR;
            end
          endcase
        end
      end

      S_PUT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = addr_i;
        ram_req_o.wdata = {color_i, ch_q};
        tab_left_d      = tab_left_q - 1'b1;
        if (col_q == COL_W'(COLUMNS - 1)) begin
          col_d = '0;
          if (row_q == ROW_W'(ROWS - 1)) begin
            start_scroll = 1'b1;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
        if (!start_scroll && tab_left_q == TAB_CNT_W'(1)) begin
          fin = 1'b1;
        end
      end

      S_BACK: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = addr_i;
        ram_req_o.wdata = blank_cell;
        fin             = 1'b1;
      end

      S_READ: begin
        pos_o        = rpos_q;
        ram_req_o.re = 1'b1;
        ram_req_o.raddr = addr_i;
        state_d      = S_READ_WAIT;
      end

      S_READ_WAIT: begin
        fin      = 1'b1;
        fin_cell = ram_rdata_i;
      end

      S_SCROLL: begin
        // Write the cell fetched in the previous cycle, fetch the one a row below.
        ram_req_o.we    = pend_q;
        ram_req_o.waddr = pend_addr_q;
        ram_req_o.wdata = pend_blank_q ? blank_cell : ram_rdata_i;
        if (idx_q < ADDR_W'(CELLS - COLUMNS)) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_q + ADDR_W'(COLUMNS);
          pend_blank_d    = 1'b0;
        end else begin
          pend_blank_d    = 1'b1;
        end
        pend_d      = 1'b1;
        pend_addr_d = idx_q;
        idx_d       = idx_q + 1'b1;
        if (idx_q == ADDR_W'(CELLS - 1)) begin
          state_d = S_SCROLL_END;
        end
      end

      S_SCROLL_END: begin
        ram_req_o.we    = pend_q;
        ram_req_o.waddr = pend_addr_q;
        ram_req_o.wdata = blank_cell;
        pend_d          = 1'b0;
        if (tab_left_q != '0) begin
          state_d = S_PUT;
        end else begin
          fin = 1'b1;
        end
      end

      S_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q;
        ram_req_o.wdata = blank_cell;
        idx_d           = idx_q + 1'b1;
        if (idx_q == ADDR_W'(CELLS - 1)) begin
          fin = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (start_scroll) begin
      scrolled_d = 1'b1;
      idx_d      = '0;
      pend_d     = 1'b0;
      state_d    = S_SCROLL;
    end

    if (fin) begin
      state_d          = S_IDLE;
      done_d           = 1'b1;
      res_d.cell_value = fin_cell;
      res_d.cursor_col = col_d;
      res_d.cursor_row = row_d;
      res_d.scrolled   = scrolled_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      col_q        <= '0;
      row_q        <= '0;
      ch_q         <= '0;
      rpos_q       <= '0;
      tab_left_q   <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      pend_addr_q  <= '0;
      pend_blank_q <= 1'b0;
      scrolled_q   <= 1'b0;
      done_q       <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      ch_q         <= ch_d;
      rpos_q       <= rpos_d;
      tab_left_q   <= tab_left_d;
      idx_q        <= idx_d;
      pend_q       <= pend_d;
      pend_addr_q  <= pend_addr_d;
      pend_blank_q <= pend_blank_d;
      scrolled_q   <= scrolled_d;
      done_q       <= done_d;
      res_q        <= res_d;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== hdl/text_console_writer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text console of 80 by 25 cells with a cursor, scrolling and screen clear.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                                             Transfer
// command   in         mode_i, char_code_i, col_i, row_i                   start high, busy low
// result    out        cell_value_o, cursor_col_o, cursor_row_o, scrolled_o  done_o high
// config    in         cfg_wdata_i (text color)                            cfg_we_i high
//
// Set cursor, return, newline without scroll and backspace at the origin finish
// straight from idle. A printable character or backspace passes through a write
// state, a read through a read and a wait state, and a tab writes its spaces one cell a cycle.
// A scroll adds a sweep that moves every row up and blanks the bottom row; a screen clear blanks every cell.
// After reset a clearing pass blanks the memory in the reset color, busy high.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
//
module text_console_writer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::COL_W-1:0]     col_i,
  input  logic [tcw_pkg::ROW_W-1:0]     row_i,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata_i,
  output logic                          done_o,
  output logic [tcw_pkg::CELL_W-1:0]    cell_value_o,
  output logic [tcw_pkg::COL_W-1:0]     cursor_col_o,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row_o,
  output logic                          scrolled_o
);
  import tcw_pkg::*;

  `include "text_console_writer_top_assert.svh"

  // The attribute byte applied to every cell that is written.
  logic [COLOR_W-1:0] text_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= COLOR_RESET;
    end else if (cfg_we_i) begin
      text_color_q <= cfg_wdata_i;
    end
  end

  tcw_pos_t          pos;
  logic [ADDR_W-1:0] addr;
  tcw_ram_req_t      ram_req;
  logic [CELL_W-1:0] ram_rdata;
  tcw_result_t       result;
  logic              cursor_on_screen;
  logic              cursor_on_bottom;

  // The sequencer owns the cursor and walks the memory for scroll and clear.
  tcw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .char_code_i (char_code_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .color_i     (text_color_q),
    .pos_o       (pos),
    .addr_i      (addr),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .done_o      (done_o),
    .result_o    (result)
  );

  // One address unit serves writes at the cursor and reads at a given position.
  tcw_addr_unit u_addr (
    .pos_i  (pos),
    .addr_o (addr)
  );

  tcw_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign cell_value_o = result.cell_value;
  assign cursor_col_o = result.cursor_col;
  assign cursor_row_o = result.cursor_row;
  assign scrolled_o   = result.scrolled;

  // Cursor position checks used by the assertions below.
  assign cursor_on_screen = (cursor_col_o <= COL_W'(COLUMNS - 1)) &&
                            (cursor_row_o <= ROW_W'(ROWS - 1));
  assign cursor_on_bottom = (cursor_row_o == ROW_W'(ROWS - 1));

  // An accepted command either completes in the next cycle or keeps the block busy.
  `TCW_ASSERT_NEXT(a_accept_progress, start && !busy, done_o || busy, "command lost")
  // A reported cursor always lies on the screen.
  `TCW_ASSERT_SAME(a_cursor_range, done_o, cursor_on_screen, "cursor off screen")
  // After a scroll the cursor sits on the bottom row.
  `TCW_ASSERT_SAME(a_scroll_row, done_o && scrolled_o, cursor_on_bottom, "cursor off bottom")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives console commands through the start/busy handshake and checks every
// result strobe against a shadow screen kept inside the testbench.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  // A run with no transfer for this many cycles is taken as a hang. The limit lies
  // well above the slowest single command (a tab that wraps and scrolls), the
  // reset clearing pass and the closing wait.
  localparam int STALL_LIMIT = 10000;
  localparam int DRAIN_CYCLES = 2100;
  localparam int RANDOM_PER_PHASE = 100;

  // One console command as it appears on the input ports.
  typedef struct packed {
    tcw_mode_e         mode;
    logic [CHAR_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_cmd_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode_i = '0;
  logic [CHAR_W-1:0]  char_code_i = '0;
  logic [COL_W-1:0]   col_i = '0;
  logic [ROW_W-1:0]   row_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [COLOR_W-1:0] cfg_wdata_i = '0;
  logic               done_o;
  logic [CELL_W-1:0]  cell_value_o;
  logic [COL_W-1:0]   cursor_col_o;
  logic [ROW_W-1:0]   cursor_row_o;
  logic               scrolled_o;

  text_console_writer_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .char_code_i  (char_code_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .cell_value_o (cell_value_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .scrolled_o   (scrolled_o)
  );

  // Commands waiting to be offered, and the status each accepted one should
  // produce, oldest first.
  console_cmd_t cmd_backlog[$];
  tcw_result_t  expected_status[$];

  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  bit          idling_on = 1'b1;

  // Shadow copy of the console: the cell grid, the cursor and the text color.
  logic [CELL_W-1:0]  shadow_screen [CELLS];
  int unsigned        cur_x;
  int unsigned        cur_y;
  logic [COLOR_W-1:0] shadow_color;
  bit                 scroll_flag;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow console.
  // --------------------------------------------------------------------------
  function automatic void blank_all();
    for (int i = 0; i < CELLS; i++) begin
      shadow_screen[ADDR_W'(i)] = {shadow_color, CH_BLANK};
    end
  endfunction

  // Once the cursor has moved below the last row, every row moves up by one,
  // the bottom row is blanked in the current color and the cursor stays on it.
  function automatic void scroll_when_past_bottom();
    if (cur_y >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
        shadow_screen[ADDR_W'(i)] = shadow_screen[ADDR_W'(i + COLUMNS)];
      end
      for (int c = 0; c < COLUMNS; c++) begin
        shadow_screen[ADDR_W'((ROWS - 1) * COLUMNS + c)] = {shadow_color, CH_BLANK};
      end
      cur_y = ROWS - 1;
      scroll_flag = 1'b1;
    end
  endfunction

  function automatic void advance_line();
    cur_x = 0;
    cur_y++;
    scroll_when_past_bottom();
  endfunction

  // A stored character advances the cursor; passing the last column acts as
  // a newline, which may in turn scroll.
  function automatic void store_glyph(logic [CHAR_W-1:0] code);
    shadow_screen[ADDR_W'(cur_y * COLUMNS + cur_x)] = {shadow_color, code};
    cur_x++;
    if (cur_x >= COLUMNS) begin
      advance_line();
    end
  endfunction

  // Backspace steps back across a line start but never past the origin, and
  // blanks the cell it lands on.
  function automatic void erase_back();
    if (cur_x == 0) begin
      if (cur_y == 0) begin
        return;
      end
      cur_y--;
      cur_x = COLUMNS - 1;
    end else begin
      cur_x--;
    end
    shadow_screen[ADDR_W'(cur_y * COLUMNS + cur_x)] = {shadow_color, CH_BLANK};
  endfunction

  // Applies one command to the shadow console and returns the status the
  // block should report for it.
  function automatic tcw_result_t console_step(console_cmd_t cmd);
    tcw_result_t res;
    int unsigned c;
    int unsigned r;
    int unsigned spaces;
    c = cmd.col;
    r = cmd.row;
    if (c >= COLUMNS) c = COLUMNS - 1;
    if (r >= ROWS) r = ROWS - 1;
    scroll_flag = 1'b0;
    res = '0;
    case (cmd.mode)
      MODE_PUT: begin
        case (cmd.code)
          CH_NEWLINE: advance_line();
          CH_RETURN: cur_x = 0;
          CH_TAB: begin
            spaces = TAB_WIDTH - (cur_x % TAB_WIDTH);
            repeat (spaces) store_glyph(CH_BLANK);
          end
          CH_BACKSPACE: erase_back();
          default: store_glyph(cmd.code);
        endcase
      end
      MODE_READ: res.cell_value = shadow_screen[ADDR_W'(r * COLUMNS + c)];
      MODE_SET: begin
        cur_x = c;
        cur_y = r;
      end
      default: begin
        blank_all();
        cur_x = 0;
        cur_y = 0;
      end
    endcase
    res.cursor_col = cur_x[COL_W-1:0];
    res.cursor_row = cur_y[ROW_W-1:0];
    res.scrolled   = scroll_flag;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Command generation.
  // --------------------------------------------------------------------------
  function automatic console_cmd_t make_cmd(tcw_mode_e mode, logic [CHAR_W-1:0] code,
                                            logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    console_cmd_t cmd;
    cmd.mode = mode;
    cmd.code = code;
    cmd.col  = col;
    cmd.row  = row;
    return cmd;
  endfunction

  // Mostly put commands, with control codes frequent enough to wrap, tab and
  // back up often. Cursor moves favor the bottom rows and the right edge so
  // that newlines and line wraps scroll regularly. Fields a mode ignores still
  // carry random values so every input bit toggles.
  function automatic console_cmd_t random_cmd();
    console_cmd_t cmd;
    int unsigned  pick;
    cmd.code = CHAR_W'($urandom_range(0, 255));
    cmd.col  = COL_W'($urandom_range(0, 127));
    cmd.row  = ROW_W'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      cmd.mode = MODE_PUT;
      case ($urandom_range(0, 9))
        0: cmd.code = CH_NEWLINE;
        1: cmd.code = CH_TAB;
        2: cmd.code = CH_BACKSPACE;
        3: cmd.code = CH_RETURN;
        default: ;
      endcase
    end else if (pick < 77) begin
      cmd.mode = MODE_READ;
    end else if (pick < 96) begin
      cmd.mode = MODE_SET;
      if ($urandom_range(0, 1) == 1) cmd.row = ROW_W'($urandom_range(ROWS - 3, 31));
      if ($urandom_range(0, 2) == 0) cmd.col = COL_W'($urandom_range(COLUMNS - 6, 127));
    end else begin
      cmd.mode = MODE_CLEAR;
    end
    return cmd;
  endfunction

  task automatic enqueue(console_cmd_t cmd);
    cmd_backlog.push_back(cmd);
    issued_count++;
  endtask

  // Returns once every queued command has been accepted, every status has
  // arrived and the block has gone idle.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (!(accepted_count == issued_count && expected_status.size() == 0 && !busy));
  endtask

  // The color register may only change while the block is idle. No command
  // can be accepted around this write, so the shadow color is updated here.
  task automatic write_color(logic [COLOR_W-1:0] color);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= color;
    shadow_color = color;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(logic [COLOR_W-1:0] color);
    wait_drained();
    write_color(color);
    repeat (RANDOM_PER_PHASE) enqueue(random_cmd());
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence.
  // --------------------------------------------------------------------------
  initial begin
    shadow_color = COLOR_RESET;
    blank_all();
    cur_x = 0;
    cur_y = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, run with the reset color. The block runs its clearing
    // pass first; the driver simply waits for busy to drop.
    enqueue(make_cmd(MODE_READ, 8'h41, 7'd0, 5'd0));         // reset contents
    enqueue(make_cmd(MODE_READ, 8'hFF, 7'd127, 5'd31));      // clamped read
    enqueue(make_cmd(MODE_PUT, 8'h41, 7'd127, 5'd31));
    enqueue(make_cmd(MODE_PUT, 8'h00, 7'd0, 5'd0));          // code zero is stored
    enqueue(make_cmd(MODE_PUT, 8'hFF, 7'd5, 5'd5));
    enqueue(make_cmd(MODE_PUT, CH_TAB, 7'd0, 5'd0));         // tab from column 3
    enqueue(make_cmd(MODE_PUT, CH_BACKSPACE, 7'd0, 5'd0));
    enqueue(make_cmd(MODE_PUT, CH_RETURN, 7'd0, 5'd0));
    enqueue(make_cmd(MODE_PUT, CH_NEWLINE, 7'd0, 5'd0));
    enqueue(make_cmd(MODE_SET, 8'h00, 7'd0, 5'd0));
    enqueue(make_cmd(MODE_PUT, CH_BACKSPACE, 7'd0, 5'd0));   // at the origin
    enqueue(make_cmd(MODE_SET, 8'h00, 7'd127, 5'd31));       // clamps to 79,24
    enqueue(make_cmd(MODE_PUT, 8'h5A, 7'd0, 5'd0));          // wrap and scroll
    enqueue(make_cmd(MODE_READ, 8'h00, 7'd79, 5'd23));       // moved up one row
    enqueue(make_cmd(MODE_SET, 8'h00, 7'd78, 5'd24));
    enqueue(make_cmd(MODE_PUT, CH_TAB, 7'd0, 5'd0));         // tab that scrolls
    enqueue(make_cmd(MODE_SET, 8'h00, 7'd10, 5'd24));
    enqueue(make_cmd(MODE_PUT, CH_NEWLINE, 7'd0, 5'd0));     // newline that scrolls
    enqueue(make_cmd(MODE_SET, 8'h00, 7'd0, 5'd1));
    enqueue(make_cmd(MODE_PUT, CH_BACKSPACE, 7'd0, 5'd0));   // back across a line start
    enqueue(make_cmd(MODE_SET, 8'h00, 7'd79, 5'd3));
    enqueue(make_cmd(MODE_PUT, 8'h78, 7'd0, 5'd0));          // wrap without scroll
    enqueue(make_cmd(MODE_READ, 8'h00, 7'd79, 5'd3));
    enqueue(make_cmd(MODE_CLEAR, 8'h00, 7'd0, 5'd0));
    enqueue(make_cmd(MODE_READ, 8'h00, 7'd5, 5'd5));

    // Random phases, each under its own text color, extremes included.
    random_phase(8'h00);
    random_phase(8'hFF);
    random_phase(8'($urandom_range(0, 255)));
    random_phase(8'hA5);

    // The last phase runs without any idle cycles on the command side.
    wait_drained();
    idling_on = 1'b0;
    write_color(8'($urandom_range(0, 255)));
    repeat (RANDOM_PER_PHASE) enqueue(random_cmd());

    // Let any stray strobe show up before the verdict.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS text_console_writer_top");
    end else begin
      $display("FAIL text_console_writer_top");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver. A command stays on the ports with start high until the block
  // takes it. After a transfer, a random burst of idle cycles may follow, so
  // the next command arrives at varying points of the block's work.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    console_cmd_t next_cmd;
    int unsigned  idle_left;
    if (!rst_ni) begin
      start     <= 1'b0;
      idle_left = 0;
    end else if (!start || !busy) begin
      if (start && idling_on && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(1, 11);
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        next_cmd = cmd_backlog.pop_front();
        start       <= 1'b1;
        mode_i      <= next_cmd.mode;
        char_code_i <= next_cmd.code;
        col_i       <= next_cmd.col;
        row_i       <= next_cmd.row;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Both the command transfer and the result strobe are handled in
  // this one process, so the expectation is always queued before its result
  // can be compared, whatever the order of processes within a time step.
  // --------------------------------------------------------------------------
  task automatic check_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_proc
    console_cmd_t seen;
    tcw_result_t  want;
    if (rst_ni) begin
      if (start && !busy) begin
        seen.mode = tcw_mode_e'(mode_i);
        seen.code = char_code_i;
        seen.col  = col_i;
        seen.row  = row_i;
        expected_status.push_back(console_step(seen));
        accepted_count++;
      end
      if (done_o) begin
        if (expected_status.size() == 0) begin
          $display("%0t ns: result with nothing expected, cell 0x%0h cursor %0d,%0d",
                   $time, cell_value_o, cursor_col_o, cursor_row_o);
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("cell_value", want.cell_value, cell_value_o);
          check_field("cursor_col", want.cursor_col, cursor_col_o);
          check_field("cursor_row", want.cursor_row, cursor_row_o);
          check_field("scrolled", want.scrolled, scrolled_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run when neither side has transferred for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL text_console_writer_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
